@@ hw/rtl/olc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package olc_pkg;

  localparam int MAX_LINES   = 4096;
  localparam int OFFSET_BITS = 24;

  localparam int IDX_W  = $clog2(MAX_LINES);   // table address
  localparam int LINE_W = 13;                  // line_number field
  localparam int COL_W  = 25;                  // column_number field
  localparam int CNT_W  = IDX_W + 1;           // line count, holds MAX_LINES
  localparam int SIZE_W = OFFSET_BITS + 1;     // text size, holds 2^OFFSET_BITS

  localparam logic [CNT_W-1:0]  LINE_CAP     = CNT_W'(MAX_LINES);
  localparam logic [SIZE_W-1:0] OFFSET_LIMIT = SIZE_W'(1) << OFFSET_BITS;
  localparam logic [7:0]        NEWLINE      = 8'h0A;

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  text_byte;
    logic        range_present;
    logic [23:0] range_begin;
    logic [23:0] range_end;
  } olc_in_word_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_number;
    logic [COL_W-1:0]  column_number;
    logic [1:0]        status;
  } olc_out_word_t;

  // search unit status towards the top level
  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic [IDX_W-1:0]       idx;
    logic [OFFSET_BITS-1:0] start;
  } olc_srch_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/olc_line_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module olc_line_ram (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [olc_pkg::IDX_W-1:0]      wr_addr,
  input  wire logic [olc_pkg::OFFSET_BITS-1:0] wr_data,
  input  wire logic                           rd_en,
  input  wire logic [olc_pkg::IDX_W-1:0]      rd_addr,
  output      logic [olc_pkg::OFFSET_BITS-1:0] rd_data
);
  import olc_pkg::*;

  logic [OFFSET_BITS-1:0] mem [MAX_LINES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/olc_search.sv @@
`timescale 1ns / 1ps
`default_nettype none
module olc_search (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic                            present,
  input  wire logic [olc_pkg::OFFSET_BITS-1:0] pos,
  input  wire logic [olc_pkg::CNT_W-1:0]       line_total,
  input  wire logic                            take,
  output      logic                            rd_en,
  output      logic [olc_pkg::IDX_W-1:0]       rd_addr,
  input  wire logic [olc_pkg::OFFSET_BITS-1:0] rd_data,
  output      olc_pkg::olc_srch_stat_t         stat
);
  import olc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_STEP, S_DONE} state_t;

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       lo_r, lo_nxt;
  logic [CNT_W-1:0]       hi_r, hi_nxt;
  logic [IDX_W-1:0]       mid_r;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0]       span;
  logic                   more;
  logic [IDX_W-1:0]       mid_nxt;

  // next interval; the read for its midpoint is issued in the same cycle
  always_comb begin
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      S_IDLE: begin
        lo_nxt    = '0;
        hi_nxt    = present ? line_total : CNT_W'(1);
        start_nxt = '0;
        pos_nxt   = pos;
      end
      S_STEP: begin
        if (rd_data <= pos_r) begin
          lo_nxt    = mid_r;
          start_nxt = rd_data;
        end else begin
          hi_nxt = {1'b0, mid_r};
        end
      end
      default: ;
    endcase
    span    = hi_nxt - {1'b0, lo_nxt};
    more    = span > CNT_W'(1);
    mid_nxt = lo_nxt + span[CNT_W-1:1];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = more ? S_STEP : S_DONE;
      S_STEP:  if (!more) state_nxt = S_DONE;
      S_DONE:  if (take)  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign rd_en   = more && ((state_r == S_IDLE && start) || state_r == S_STEP);
  assign rd_addr = mid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if ((state_r == S_IDLE && start) || state_r == S_STEP) begin
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      mid_r   <= mid_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign stat.busy  = state_r != S_IDLE;
  assign stat.done  = state_r == S_DONE;
  assign stat.idx   = lo_r;
  assign stat.start = start_r;

endmodule
`default_nettype wire

@@ hw/rtl/offset_to_line_column_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Word            Handshake
// in_      input      olc_in_word_t   in_valid / in_ready
// out_     output     olc_out_word_t  out_valid / out_ready
//
// Load, clear and unused words go back to back while no query is busy.
// A query with a range issues the first read in the accepting cycle; each search
// step resolves one read and issues the next, and the result then moves out once
// the output register is free. With no range, or with one line, no read is made.
// Reset (rst_n low, synchronous): one line at offset 0; the RAM is not cleared.
// in_ready is low while a query searches or its result waits; loads wait too.
module offset_to_line_column_unit (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire olc_pkg::olc_in_word_t  in_data,
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      olc_pkg::olc_out_word_t out_data
);
  import olc_pkg::*;

  // text state
  logic [CNT_W-1:0]  lt_r, lt_nxt;    // recorded line starts
  logic [SIZE_W-1:0] ts_r, ts_nxt;    // bytes loaded
  logic              ovf_r, ovf_nxt;  // sticky overflow

  // query context held while searching
  logic        present_r;
  logic [23:0] begin_r;
  logic [1:0]  status_r;

  logic          out_valid_r;
  olc_out_word_t out_data_r;

  logic                   in_acc;
  logic                   q_start;
  logic                   take;
  logic                   wr_en;
  logic [SIZE_W-1:0]      ts_inc;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [OFFSET_BITS-1:0] rd_data;
  olc_srch_stat_t         srch;
  logic [1:0]             q_status;

  assign in_ready = !srch.busy;
  assign in_acc   = in_valid && in_ready;
  assign q_start  = in_acc && in_data.cmd == CMD_QUERY;
  assign ts_inc   = ts_r + SIZE_W'(1);

  // loads, clears and the line-start write
  always_comb begin
    lt_nxt  = lt_r;
    ts_nxt  = ts_r;
    ovf_nxt = ovf_r;
    wr_en   = 1'b0;
    if (in_acc) begin
      unique case (in_data.cmd)
        CMD_CLEAR: begin
          lt_nxt  = CNT_W'(1);
          ts_nxt  = '0;
          ovf_nxt = 1'b0;
        end
        CMD_LOAD: begin
          if (ts_r >= OFFSET_LIMIT) begin
            ovf_nxt = 1'b1;
          end else begin
            ts_nxt = ts_inc;
            if (in_data.text_byte == NEWLINE) begin
              if (ts_inc >= OFFSET_LIMIT || lt_r >= LINE_CAP) begin
                ovf_nxt = 1'b1;
              end else begin
                wr_en  = 1'b1;
                lt_nxt = lt_r + CNT_W'(1);
              end
            end
          end
        end
        default: ;  // query handled below, unused code ignored
      endcase
    end
  end

  // overflow outranks range past end
  always_comb begin
    if (ovf_r) begin
      q_status = ST_OVF;
    end else if (in_data.range_present && {1'b0, in_data.range_end} > ts_r) begin
      q_status = ST_RANGE;
    end else begin
      q_status = ST_OK;
    end
  end

  olc_line_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (lt_r[IDX_W-1:0]),
    .wr_data (ts_inc[OFFSET_BITS-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  olc_search u_srch (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (q_start),
    .present    (in_data.range_present),
    .pos        (in_data.range_begin),
    .line_total (lt_r),
    .take       (take),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .stat       (srch)
  );

  // result moves into the output register once it is free
  assign take = srch.done && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r        <= CNT_W'(1);
      ts_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      lt_r  <= lt_nxt;
      ts_r  <= ts_nxt;
      ovf_r <= ovf_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (q_start) begin
      present_r <= in_data.range_present;
      begin_r   <= in_data.range_begin;
      status_r  <= q_status;
    end
    if (take) begin
      out_data_r.status <= status_r;
      if (present_r) begin
        out_data_r.line_number   <= LINE_W'(srch.idx) + LINE_W'(1);
        out_data_r.column_number <= COL_W'(begin_r) - COL_W'(srch.start) + COL_W'(1);
      end else begin
        out_data_r.line_number   <= '0;
        out_data_r.column_number <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // line count stays within the table
  a_lt_range: assert property (@(posedge clk) disable iff (!rst_n)
    lt_r >= CNT_W'(1) && lt_r <= LINE_CAP)
    else $error("line count out of range");

  // a clear word restores the empty text
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.cmd == CMD_CLEAR |=> lt_r == CNT_W'(1) && ts_r == '0 && !ovf_r)
    else $error("clear did not restore text state");

  // a query holds off further words in the cycle after it is accepted
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_start |=> !in_ready)
    else $error("input taken during search");

  // found line lies within the recorded lines
  a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
    take && present_r |-> {1'b0, srch.idx} < lt_r)
    else $error("line number beyond table");

endmodule
`default_nettype wire
